// ===== src/fbct_pkg.sv =====
// ----------------------------------------------------------------------------
// Frustum box cull test: shared types and constants
// Plane packing, configuration register indexes and the pipeline control
// bundle used by every module of the block.
// ----------------------------------------------------------------------------
package fbct_pkg;

    localparam int FIELD_BITS     = 16;
    localparam int EXTENT_BITS    = 15;
    localparam int D_SHIFT        = 14;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 64;
    localparam int PLANE_REGS     = 6;
    localparam int NUM_STAGES     = 4;

    localparam logic [CFG_INDEX_BITS-1:0] REG_MARGIN = 3'd6;

    typedef struct packed {
        logic signed [FIELD_BITS-1:0] d;
        logic signed [FIELD_BITS-1:0] nz;
        logic signed [FIELD_BITS-1:0] ny;
        logic signed [FIELD_BITS-1:0] nx;
    } t_plane;

    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
        logic [NUM_STAGES-1:0] valid;
    } t_pipe_ctl;

endpackage

// ===== src/fbct_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Frustum box cull test: configuration registers
// Holds the six packed planes and the cull margin written through the
// plain write port.
// ----------------------------------------------------------------------------
module fbct_cfg_regs (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [fbct_pkg::CFG_INDEX_BITS-1:0]    i_cfg_index,
    input  logic [fbct_pkg::CFG_DATA_BITS-1:0]     i_cfg_data,
    output fbct_pkg::t_plane                       o_plane [fbct_pkg::PLANE_REGS],
    output logic signed [fbct_pkg::FIELD_BITS-1:0] o_margin
);

    fbct_pkg::t_plane                       r_plane [fbct_pkg::PLANE_REGS];
    logic signed [fbct_pkg::FIELD_BITS-1:0] r_margin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < fbct_pkg::PLANE_REGS; p++) begin
                r_plane[p] <= '0;
            end
            r_margin <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_index < fbct_pkg::CFG_INDEX_BITS'(fbct_pkg::PLANE_REGS)) begin
                r_plane[i_cfg_index] <= fbct_pkg::t_plane'(i_cfg_data);
            end else if (i_cfg_index == fbct_pkg::REG_MARGIN) begin
                r_margin <= $signed(i_cfg_data[fbct_pkg::FIELD_BITS-1:0]);
            end
        end
    end

    assign o_plane  = r_plane;
    assign o_margin = r_margin;

endmodule

// ===== src/fbct_pipe_ctrl.sv =====
// ----------------------------------------------------------------------------
// Frustum box cull test: pipeline control
// Valid bits for each register stage and the load enables that let an
// item move on whenever the stage ahead is empty or moving.
// ----------------------------------------------------------------------------
module fbct_pipe_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_out_stall,
    output logic                 o_in_stall,
    output fbct_pkg::t_pipe_ctl  o_ctl
);

    logic [fbct_pkg::NUM_STAGES-1:0] r_valid;
    logic [fbct_pkg::NUM_STAGES-1:0] n_ready;

    always_comb begin
        n_ready[fbct_pkg::NUM_STAGES-1] = !r_valid[fbct_pkg::NUM_STAGES-1] || !i_out_stall;
        for (int k = fbct_pkg::NUM_STAGES - 2; k >= 0; k--) begin
            n_ready[k] = !r_valid[k] || n_ready[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (n_ready[0]) begin
                r_valid[0] <= i_in_valid;
            end
            for (int k = 1; k < fbct_pkg::NUM_STAGES; k++) begin
                if (n_ready[k]) begin
                    r_valid[k] <= r_valid[k-1];
                end
            end
        end
    end

    assign o_in_stall  = !n_ready[0];
    assign o_ctl.load  = n_ready;
    assign o_ctl.valid = r_valid;

endmodule

// ===== src/fbct_plane_dot.sv =====
// ----------------------------------------------------------------------------
// Frustum box cull test: plane dot products
// For one plane, selects the positive and negative vertex per axis,
// multiplies by the normal in one stage and sums the three terms in the next.
// ----------------------------------------------------------------------------
module fbct_plane_dot #(
    parameter int HW = 17
) (
    input  logic                           i_clk,
    input  fbct_pkg::t_pipe_ctl            i_ctl,
    input  fbct_pkg::t_plane               i_plane,
    input  logic signed [HW-1:0]           i_lo [3],
    input  logic signed [HW-1:0]           i_hi [3],
    output logic signed [HW+fbct_pkg::FIELD_BITS+1:0] o_dp_pos,
    output logic signed [HW+fbct_pkg::FIELD_BITS+1:0] o_dp_neg
);

    localparam int PW = HW + fbct_pkg::FIELD_BITS;
    localparam int SW = PW + 2;

    logic signed [fbct_pkg::FIELD_BITS-1:0] w_n [3];
    logic signed [PW-1:0] r_pp [3];
    logic signed [PW-1:0] r_pn [3];
    logic signed [SW-1:0] r_dp_pos;
    logic signed [SW-1:0] r_dp_neg;

    assign w_n[0] = i_plane.nx;
    assign w_n[1] = i_plane.ny;
    assign w_n[2] = i_plane.nz;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[1]) begin
            for (int a = 0; a < 3; a++) begin
                r_pp[a] <= PW'(w_n[a]) * PW'((w_n[a] > 0) ? i_hi[a] : i_lo[a]);
                r_pn[a] <= PW'(w_n[a]) * PW'((w_n[a] < 0) ? i_hi[a] : i_lo[a]);
            end
        end
        if (i_ctl.load[2]) begin
            r_dp_pos <= SW'(r_pp[0]) + SW'(r_pp[1]) + SW'(r_pp[2]);
            r_dp_neg <= SW'(r_pn[0]) + SW'(r_pn[1]) + SW'(r_pn[2]);
        end
    end

    assign o_dp_pos = r_dp_pos;
    assign o_dp_neg = r_dp_neg;

endmodule

// ===== src/frustum_box_cull_test.sv =====
// ----------------------------------------------------------------------------
// Frustum box cull test
// Classifies one axis-aligned box per item against the configured planes,
// using the positive vertex for the intersect test and the negative vertex
// for the containment test.
//
// The block takes one box every cycle while the input is not stalled; the
// box maximum is formed in the first register stage, every plane's vertex
// products in the second, their sums in the third, and the threshold
// compares with the reduction over planes feed the output register. A stall
// on the result side backs up through the stage valid bits in the same
// cycle, so up to four items are held in flight without loss. Planes are the
// six written through the configuration port; with fewer planes configured
// by NUM_PLANES only the first ones are tested, and planes beyond the sixth
// never reject a box.
// ----------------------------------------------------------------------------
module frustum_box_cull_test #(
    parameter int NUM_PLANES = 6,
    parameter int COORD_BITS = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [fbct_pkg::CFG_INDEX_BITS-1:0]    i_cfg_index,
    input  logic [fbct_pkg::CFG_DATA_BITS-1:0]     i_cfg_data,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic signed [COORD_BITS-1:0]           i_corner_x,
    input  logic signed [COORD_BITS-1:0]           i_corner_y,
    input  logic signed [COORD_BITS-1:0]           i_corner_z,
    input  logic [fbct_pkg::EXTENT_BITS-1:0]       i_extent_x,
    input  logic [fbct_pkg::EXTENT_BITS-1:0]       i_extent_y,
    input  logic [fbct_pkg::EXTENT_BITS-1:0]       i_extent_z,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic                                   o_touches,
    output logic                                   o_fully_inside
);

    localparam int HW = ((COORD_BITS > fbct_pkg::EXTENT_BITS) ? COORD_BITS
                                                              : fbct_pkg::FIELD_BITS) + 1;
    localparam int SW = HW + fbct_pkg::FIELD_BITS + 2;
    localparam int NP_USED = (NUM_PLANES < fbct_pkg::PLANE_REGS) ? NUM_PLANES
                                                                 : fbct_pkg::PLANE_REGS;

    fbct_pkg::t_plane                       w_plane [fbct_pkg::PLANE_REGS];
    logic signed [fbct_pkg::FIELD_BITS-1:0] w_margin;
    fbct_pkg::t_pipe_ctl                    w_ctl;

    logic signed [HW-1:0] r_lo [3];
    logic signed [HW-1:0] r_hi [3];
    logic signed [SW-1:0] w_dp_pos [NP_USED];
    logic signed [SW-1:0] w_dp_neg [NP_USED];
    logic [NP_USED-1:0]   w_touch;
    logic [NP_USED-1:0]   w_inside;
    logic                 r_touches;
    logic                 r_inside;

    fbct_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_plane     (w_plane),
        .o_margin    (w_margin)
    );

    fbct_pipe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .o_in_stall  (o_in_stall),
        .o_ctl       (w_ctl)
    );

    always_ff @(posedge i_clk) begin
        if (w_ctl.load[0]) begin
            r_lo[0] <= HW'(i_corner_x);
            r_lo[1] <= HW'(i_corner_y);
            r_lo[2] <= HW'(i_corner_z);
            r_hi[0] <= HW'(i_corner_x) + $signed(HW'(i_extent_x));
            r_hi[1] <= HW'(i_corner_y) + $signed(HW'(i_extent_y));
            r_hi[2] <= HW'(i_corner_z) + $signed(HW'(i_extent_z));
        end
    end

    for (genvar p = 0; p < NP_USED; p++) begin : g_plane
        logic signed [SW-1:0] w_thr_pos;
        logic signed [SW-1:0] w_thr_neg;

        fbct_plane_dot #(
            .HW (HW)
        ) u_dot (
            .i_clk    (i_clk),
            .i_ctl    (w_ctl),
            .i_plane  (w_plane[p]),
            .i_lo     (r_lo),
            .i_hi     (r_hi),
            .o_dp_pos (w_dp_pos[p]),
            .o_dp_neg (w_dp_neg[p])
        );

        assign w_thr_pos = -((SW'(w_plane[p].d) + SW'(w_margin)) <<< fbct_pkg::D_SHIFT);
        assign w_thr_neg = -(SW'(w_plane[p].d) <<< fbct_pkg::D_SHIFT);
        assign w_touch[p]  = !(w_dp_pos[p] < w_thr_pos);
        assign w_inside[p] = !(w_dp_neg[p] < w_thr_neg);
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.load[3]) begin
            r_touches <= &w_touch;
            r_inside  <= &w_inside;
        end
    end

    assign o_out_valid    = w_ctl.valid[fbct_pkg::NUM_STAGES-1];
    assign o_touches      = r_touches;
    assign o_fully_inside = r_inside;

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (&w_ctl.valid))
        else $error("input stalled while a pipeline stage is empty");

    a_accept_enters_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> w_ctl.valid[0])
        else $error("accepted item did not enter the first stage");

    a_output_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl.valid[fbct_pkg::NUM_STAGES-2] && !o_out_valid) |=> o_out_valid)
        else $error("finished item did not reach an empty output register");

endmodule
